FILE: rtl/core/gb2312_glyph_layout_macros.svh
// Assertion macros for the glyph layout checker
`ifndef GB2312_GLYPH_LAYOUT_MACROS_SVH
`define GB2312_GLYPH_LAYOUT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define GBGL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent
`define GBGL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gbgl_pkg.sv
`default_nettype none

package gbgl_pkg;

	// Default sizing
	localparam int unsigned MID_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 4;
	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned FB_WIDTH_LIMIT = 8191;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FONT_SIZE_MODE = 3'd0,
		CFG_TEXT_COLOR     = 3'd1,
		CFG_FB_BASE        = 3'd2,
		CFG_FB_STRIDE      = 3'd3,
		CFG_FB_WIDTH       = 3'd4
	} cfg_index_t;

	// Font size modes
	localparam logic [1:0] MODE_12 = 2'd0;
	localparam logic [1:0] MODE_16 = 2'd1;
	localparam logic [1:0] MODE_24 = 2'd2;

	// Code point arithmetic
	localparam logic [7:0] GB_BASE     = 8'hA0;
	localparam int unsigned ROW_CELLS  = 94;
	localparam int unsigned ASCII_FIRST = 32;
	localparam int unsigned SKIP_AREAS = 15;

	typedef struct packed {
		logic [6:0] bytes;
		logic [4:0] rows;
		logic [1:0] rowb;
		logic [4:0] adv;
	} geom_t;

	typedef struct packed {
		logic [1:0]  font_size_mode;
		logic [23:0] text_color;
		logic [31:0] fb_base;
		logic [13:0] fb_stride;
		logic [12:0] fb_width;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        first_byte;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
	} glyph_request_t;

	typedef struct packed {
		logic [2:0]  font_select;
		logic [31:0] font_offset;
		logic [6:0]  glyph_bytes;
		logic [4:0]  glyph_rows;
		logic [1:0]  row_bytes;
		logic [4:0]  pen_advance;
		logic [31:0] dest_address;
		logic [15:0] color565;
	} glyph_result_t;

	// Classified character handed from front to back
	typedef struct packed {
		logic        chinese;
		logic [1:0]  mode;
		logic [7:0]  lead;
		logic [7:0]  code;
		logic [13:0] col;
		logic [11:0] row;
	} front_item_t;

	// Glyph geometry per size mode and script
	function automatic geom_t geom(input logic [1:0] mode, input logic ascii);
		geom_t g;
		case ({mode, ascii})
			{MODE_12, 1'b0}: g = '{bytes: 7'd24, rows: 5'd12, rowb: 2'd2, adv: 5'd12};
			{MODE_12, 1'b1}: g = '{bytes: 7'd12, rows: 5'd12, rowb: 2'd1, adv: 5'd8};
			{MODE_16, 1'b0}: g = '{bytes: 7'd32, rows: 5'd16, rowb: 2'd2, adv: 5'd16};
			{MODE_16, 1'b1}: g = '{bytes: 7'd16, rows: 5'd16, rowb: 2'd1, adv: 5'd8};
			{MODE_24, 1'b0}: g = '{bytes: 7'd72, rows: 5'd24, rowb: 2'd3, adv: 5'd24};
			{MODE_24, 1'b1}: g = '{bytes: 7'd48, rows: 5'd24, rowb: 2'd2, adv: 5'd16};
			default:         g = '{bytes: 7'd0, rows: 5'd0, rowb: 2'd0, adv: 5'd0};
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gbgl_fifo.sv
`default_nettype none

module gbgl_fifo #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [DATA_W-1:0]          pdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [DATA_W-1:0]               qdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign qdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= pdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/gbgl_front.sv
`default_nettype none

module gbgl_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire gbgl_pkg::glyph_request_t request,
	input  wire gbgl_pkg::cfg_t          cfg,
	input  wire logic                    item_full,
	output logic                         item_push,
	output gbgl_pkg::front_item_t        item
);

	logic        lead_pending_q;
	logic [7:0]  lead_byte_q;
	logic [11:0] base_x_q;
	logic [11:0] base_y_q;
	logic [12:0] pen_q;

	logic               accept;
	logic [11:0]        bx;
	logic [11:0]        by;
	logic [12:0]        pen;
	logic               lead_held;
	logic               is_lead;
	logic               mode_ok;
	logic               fits;
	logic [13:0]        col;
	gbgl_pkg::geom_t    g;

	// Classify the byte against the string state
	always_comb begin
		accept    = push && !item_full;
		bx        = request.first_byte ? request.origin_x : base_x_q;
		by        = request.first_byte ? request.origin_y : base_y_q;
		pen       = request.first_byte ? 13'd0 : pen_q;
		lead_held = request.first_byte ? 1'b0 : lead_pending_q;
		is_lead   = !lead_held && request.text_byte[7];
		mode_ok   = (cfg.font_size_mode == gbgl_pkg::MODE_12) ||
		            (cfg.font_size_mode == gbgl_pkg::MODE_16) ||
		            (cfg.font_size_mode == gbgl_pkg::MODE_24);
		g         = gbgl_pkg::geom(cfg.font_size_mode, !lead_held);
		col       = {2'b00, bx} + {1'b0, pen};
		// Clip at the right edge
		fits      = ({1'b0, col} + {10'b0, g.adv}) < {2'b00, cfg.fb_width};
		item_push = accept && !is_lead && mode_ok && fits;
		item      = '{chinese: lead_held, mode: cfg.font_size_mode, lead: lead_byte_q,
		              code: request.text_byte, col: col, row: by};
	end

	// Update pen, origin and lead byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_byte_q    <= '0;
			base_x_q       <= '0;
			base_y_q       <= '0;
			pen_q          <= '0;
		end else if (accept) begin
			base_x_q       <= bx;
			base_y_q       <= by;
			lead_pending_q <= is_lead;
			if (is_lead) begin
				lead_byte_q <= request.text_byte;
			end
			pen_q <= item_push ? 13'(pen + {8'b0, g.adv}) : pen;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/gbgl_back.sv
`default_nettype none

module gbgl_back #(
	parameter int unsigned OUT_DEPTH = gbgl_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gbgl_pkg::cfg_t                cfg,
	input  wire gbgl_pkg::front_item_t         item,
	input  wire logic                          item_empty,
	output logic                               item_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                               out_push,
	output gbgl_pkg::glyph_result_t            out_data
);

	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	logic        valid_s1;
	logic        chinese_s1;
	logic [1:0]  mode_s1;
	logic [31:0] idx_s1;
	logic [13:0] col_s1;
	logic [25:0] ystride_s1;

	logic [7:0]      area;
	logic [7:0]      loc;
	logic [31:0]     skip;
	logic [31:0]     cn_idx;
	logic [31:0]     asc_idx;
	logic [25:0]     ystride;
	gbgl_pkg::geom_t g;

	// Issue only when the result queue has a slot for everything in flight
	assign item_pop = !item_empty && (({1'b0, out_count} + (CW + 1)'(valid_s1))
	                  < (CW + 1)'(OUT_DEPTH));

	// Glyph index and row address term
	always_comb begin
		area    = item.lead - gbgl_pkg::GB_BASE;
		loc     = item.code - gbgl_pkg::GB_BASE;
		skip    = (item.mode == gbgl_pkg::MODE_24) ? 32'(gbgl_pkg::SKIP_AREAS) : 32'd0;
		cn_idx  = (({24'b0, area} - 32'd1 - skip) * 32'(gbgl_pkg::ROW_CELLS))
		          + {24'b0, loc} - 32'd1;
		asc_idx = (item.mode == gbgl_pkg::MODE_12) ?
		          ({24'b0, item.code} - 32'(gbgl_pkg::ASCII_FIRST)) : {24'b0, item.code};
		ystride = {14'b0, item.row} * {12'b0, cfg.fb_stride};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			chinese_s1 <= item.chinese;
			mode_s1    <= item.mode;
			idx_s1     <= item.chinese ? cn_idx : asc_idx;
			col_s1     <= item.col;
			ystride_s1 <= ystride;
		end
	end

	// Scale the index and form the descriptor
	always_comb begin
		g        = gbgl_pkg::geom(mode_s1, !chinese_s1);
		out_push = valid_s1;
		out_data = '{
			font_select:  {mode_s1, !chinese_s1},
			font_offset:  idx_s1 * {25'b0, g.bytes},
			glyph_bytes:  g.bytes,
			glyph_rows:   g.rows,
			row_bytes:    g.rowb,
			pen_advance:  g.adv,
			dest_address: cfg.fb_base + {17'b0, col_s1, 1'b0} + {6'b0, ystride_s1},
			color565:     {cfg.text_color[23:19], cfg.text_color[15:10], cfg.text_color[7:3]}
		};
	end

endmodule

`default_nettype wire

FILE: rtl/core/gb2312_glyph_layout.sv
`default_nettype none

// Glyph layout engine for mixed ASCII and GB2312 text. One text byte is
// taken per clock while full is low; a byte with its top bit set is held as
// a lead byte and the next byte completes the character. Each drawn
// character yields one glyph descriptor (font table, bitmap offset,
// geometry, framebuffer address, RGB565 colour); clipped characters and
// lead bytes yield none. A descriptor reaches the result ports via the
// back end register and result queue, and one result can be popped every
// cycle while empty is low. The pen and clip decision are resolved in the
// front in the cycle the byte arrives; the offset and address multiplies
// run in a one-stage back end. A queue of MID_DEPTH entries separates the
// two, and full rises only once it fills while results are not popped.
// Configuration writes take effect at once and must be made while idle.
module gb2312_glyph_layout #(
	parameter int unsigned MID_DEPTH = gbgl_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = gbgl_pkg::OUT_DEPTH_DEF,
	parameter int unsigned MAX_WIDTH = gbgl_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire gbgl_pkg::glyph_request_t           request,
	output logic                                    empty,
	input  wire logic                               pop,
	output gbgl_pkg::glyph_result_t                 result,
	input  wire logic                               cfg_write,
	input  wire logic [gbgl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gbgl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [12:0] FB_WIDTH_RST = 13'((MAX_WIDTH > gbgl_pkg::FB_WIDTH_LIMIT) ?
	                                           gbgl_pkg::FB_WIDTH_LIMIT : MAX_WIDTH);
	localparam int unsigned ITEM_W   = $bits(gbgl_pkg::front_item_t);
	localparam int unsigned RESULT_W = $bits(gbgl_pkg::glyph_result_t);

	logic [1:0]  font_size_mode_q;
	logic [23:0] text_color_q;
	logic [31:0] fb_base_q;
	logic [13:0] fb_stride_q;
	logic [12:0] fb_width_q;

	gbgl_pkg::cfg_t                      cfg;
	gbgl_pkg::front_item_t               front_item;
	gbgl_pkg::front_item_t               back_item;
	gbgl_pkg::glyph_result_t             back_result;
	logic                                front_push;
	logic                                mid_full;
	logic                                mid_empty;
	logic                                mid_pop;
	logic [ITEM_W-1:0]                   mid_q;
	logic [$clog2(MID_DEPTH+1)-1:0]      mid_count;
	logic                                out_push;
	logic [RESULT_W-1:0]                 out_q;
	logic                                out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0]      out_count;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_size_mode_q <= gbgl_pkg::MODE_16;
			text_color_q     <= 24'hFFFFFF;
			fb_base_q        <= '0;
			fb_stride_q      <= '0;
			fb_width_q       <= FB_WIDTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				gbgl_pkg::CFG_FONT_SIZE_MODE: font_size_mode_q <= cfg_data[1:0];
				gbgl_pkg::CFG_TEXT_COLOR:     text_color_q     <= cfg_data[23:0];
				gbgl_pkg::CFG_FB_BASE:        fb_base_q        <= cfg_data;
				gbgl_pkg::CFG_FB_STRIDE:      fb_stride_q      <= cfg_data[13:0];
				gbgl_pkg::CFG_FB_WIDTH:       fb_width_q       <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{font_size_mode: font_size_mode_q, text_color: text_color_q,
	               fb_base: fb_base_q, fb_stride: fb_stride_q, fb_width: fb_width_q};

	assign full      = mid_full;
	assign back_item = gbgl_pkg::front_item_t'(mid_q);
	assign result    = gbgl_pkg::glyph_result_t'(out_q);

	gbgl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.cfg       (cfg),
		.item_full (mid_full),
		.item_push (front_push),
		.item      (front_item)
	);

	gbgl_fifo #(
		.DATA_W (ITEM_W),
		.DEPTH  (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.pdata  (front_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.qdata  (mid_q),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	gbgl_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (back_item),
		.item_empty (mid_empty || (mid_count == '0)),
		.item_pop   (mid_pop),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_data   (back_result)
	);

	gbgl_fifo #(
		.DATA_W (RESULT_W),
		.DEPTH  (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push && !out_full),
		.pdata  (back_result),
		.full   (out_full),
		.pop    (pop),
		.qdata  (out_q),
		.empty  (empty),
		.count  (out_count)
	);

endmodule

`default_nettype wire

FILE: rtl/core/gbgl_checker.sv
`default_nettype none

`include "gb2312_glyph_layout_macros.svh"

module gbgl_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    empty,
	input wire logic                    pop,
	input wire gbgl_pkg::glyph_result_t result
);

	// Geometry must agree with itself
	`GBGL_ASSERT_NOW(a_bytes_rows, clk, arst_n, !empty, (result.glyph_bytes == (7'(result.glyph_rows) * 7'(result.row_bytes))), "glyph bytes differ from rows times row bytes")

	// Pen advance follows the script and size
	`GBGL_ASSERT_NOW(a_advance, clk, arst_n, !empty, (result.pen_advance == (result.font_select[0] ? (result.font_select[2] ? 5'd16 : 5'd8) : result.glyph_rows)), "pen advance does not match glyph")

	// No result names the unused size mode
	`GBGL_ASSERT_NOW(a_font_select, clk, arst_n, !empty, (result.font_select[2:1] != 2'b11), "font select out of range")

	// Hold a waiting result until it is popped
	`GBGL_ASSERT_NEXT(a_result_hold, clk, arst_n, (!empty && !pop), (!empty && $stable(result)), "waiting result changed before pop")

endmodule

bind gb2312_glyph_layout gbgl_checker u_gbgl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
